FILE: hw/rtl/hcbd_pkg.sv
// Shared types, constants and byte classifiers for the chunked body decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hcbd_pkg;

   localparam int SIZE_BITS   = 32;   // chunk size accumulator width
   localparam int LENGTH_BITS = 32;   // body length counter width
   localparam int BODY_LEN_W  = 32;   // reported body length width
   localparam int RSP_DATA_W  = 48;   // data byte + length + flag, padded to bytes

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_HT = 8'h09;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_DONE    = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            data_byte;
      logic [BODY_LEN_W-1:0] body_length;
      logic                  size_saturated;
   } hcbd_result_type;

   // {valid, value} of an ASCII hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SP) || (b == CHAR_HT) || (b == CHAR_CR) ||
             (b == CHAR_LF) || (b == CHAR_VT) || (b == CHAR_FF);
   endfunction

endpackage

FILE: hw/rtl/http_chunked_body_decoder_unit.sv
// HTTP/1.1 chunked body decoder: one body byte per request, payload and completion out.
// A result reaches rsp_ through the output register, or through the skid entry while the output is stalled.
// Throughput: one request per cycle; req_tready drops only while the skid entry holds a result.
// Reset (synchronous, active high): decoder rearms at a size line start, length and
// saturation flag cleared, output register and skid entry emptied.
// Depends on hcbd_pkg, hcbd_step, hcbd_out.
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit
   import hcbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel: raw body bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_byte
   // result channel: payload bytes and body completion
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [39:8] body_length,
                                              // [40] size_saturated, [47:41] zero
   output logic                  rsp_tuser    // [0] kind: 0 payload, 1 body complete
);

   logic            accept;
   logic            space_ok;
   logic            res_valid;
   hcbd_result_type res;
   hcbd_result_type rsp;

   // Take a request whenever the skid entry is free; the state update and the
   // result both complete in the accepting cycle.
   assign req_tready = space_ok;
   assign accept     = req_tvalid && req_tready;

   hcbd_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   // Hold the result until the consumer takes it; a second one parks in the skid.
   hcbd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .space_ok  (space_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result fields, lowest first, zero padded to whole bytes.
   assign rsp_tdata = {7'd0, rsp.size_saturated, rsp.body_length, rsp.data_byte};
   assign rsp_tuser = rsp.kind;

endmodule

FILE: hw/rtl/hcbd_step.sv
// Per-byte decoder state, updated on each accepted byte; produces at most one result.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_step
   import hcbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_accept,
   input  logic [7:0]      in_byte,
   output logic            res_valid,
   output hcbd_result_type res
);

   typedef enum logic [2:0] {
      PH_LEAD    = 3'd0,
      PH_DIGITS  = 3'd1,
      PH_REST    = 3'd2,
      PH_DATA    = 3'd3,
      PH_SKIP_A  = 3'd4,
      PH_SKIP_B  = 3'd5,
      PH_TRAILER = 3'd6
   } phase_type;

   localparam logic [SIZE_BITS-1:0]   SIZE_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   accum_ff, accum_in;
   logic [SIZE_BITS-1:0]   left_ff, left_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   cr_ff, cr_in;
   logic                   empty_ff, empty_in;
   logic                   sat_ff, sat_in;

   always_comb begin
      logic                   line_end;
      logic [4:0]             hx;
      logic                   over;
      logic [SIZE_BITS-1:0]   accum_add;
      logic [LENGTH_BITS-1:0] len_inc;

      line_end  = cr_ff && (in_byte == CHAR_LF);
      hx        = hex_decode(in_byte);
      over      = accum_ff[SIZE_BITS-1 -: 4] != 4'd0;
      accum_add = over ? SIZE_MAX : {accum_ff[SIZE_BITS-5:0], hx[3:0]};
      len_inc   = (length_ff != LEN_MAX) ? length_ff + 1'b1 : length_ff;

      phase_in  = phase_ff;
      accum_in  = accum_ff;
      left_in   = left_ff;
      length_in = length_ff;
      cr_in     = cr_ff;
      empty_in  = empty_ff;
      sat_in    = sat_ff;
      res_valid = 1'b0;
      res       = '{kind: KIND_PAYLOAD, data_byte: in_byte,
                    body_length: BODY_LEN_W'(len_inc), size_saturated: sat_ff};

      case (phase_ff)
         PH_LEAD, PH_DIGITS, PH_REST: begin
            if (line_end) begin
               cr_in    = 1'b0;
               accum_in = '0;
               if (accum_ff != '0) begin
                  left_in  = accum_ff;
                  phase_in = PH_DATA;
               end else begin
                  empty_in = 1'b1;
                  phase_in = PH_TRAILER;
               end
            end else begin
               cr_in = (in_byte == CHAR_CR);
               if (phase_ff == PH_LEAD) begin
                  if (hx[4]) begin
                     accum_in = accum_add;
                     sat_in   = sat_ff | over;
                     phase_in = PH_DIGITS;
                  end else if (!is_blank(in_byte)) begin
                     phase_in = PH_REST;
                  end
               end else if (phase_ff == PH_DIGITS) begin
                  if (hx[4]) begin
                     accum_in = accum_add;
                     sat_in   = sat_ff | over;
                  end else begin
                     phase_in = PH_REST;
                  end
               end
            end
         end
         PH_DATA: begin
            length_in = len_inc;
            left_in   = left_ff - 1'b1;
            if (left_ff == SIZE_BITS'(1)) begin
               phase_in = PH_SKIP_A;
            end
            res_valid = 1'b1;
         end
         PH_SKIP_A: begin
            phase_in = PH_SKIP_B;
         end
         PH_SKIP_B: begin
            phase_in = PH_LEAD;
            accum_in = '0;
            cr_in    = 1'b0;
         end
         PH_TRAILER: begin
            if (line_end) begin
               if (empty_ff) begin
                  // end of body: report and rearm
                  res_valid = 1'b1;
                  res       = '{kind: KIND_DONE, data_byte: 8'd0,
                                body_length: BODY_LEN_W'(length_ff),
                                size_saturated: sat_ff};
                  phase_in  = PH_LEAD;
                  accum_in  = '0;
                  left_in   = '0;
                  length_in = '0;
                  cr_in     = 1'b0;
                  empty_in  = 1'b1;
                  sat_in    = 1'b0;
               end else begin
                  cr_in    = 1'b0;
                  empty_in = 1'b1;
               end
            end else begin
               if (in_byte == CHAR_CR) begin
                  cr_in = 1'b1;
                  if (cr_ff) begin
                     empty_in = 1'b0;
                  end
               end else begin
                  cr_in    = 1'b0;
                  empty_in = 1'b0;
               end
            end
         end
         default: begin
            phase_in = PH_LEAD;
         end
      endcase

      res_valid = res_valid & in_accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         accum_ff  <= '0;
         left_ff   <= '0;
         length_ff <= '0;
         cr_ff     <= 1'b0;
         empty_ff  <= 1'b1;
         sat_ff    <= 1'b0;
      end else if (in_accept) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         left_ff   <= left_in;
         length_ff <= length_in;
         cr_ff     <= cr_in;
         empty_ff  <= empty_in;
         sat_ff    <= sat_in;
      end
   end

   a_done_rearms: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_DONE |=>
         phase_ff == PH_LEAD && length_ff == '0 && !sat_ff)
      else $error("completion did not rearm the decoder");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_accum_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LEAD || phase_ff == PH_TRAILER |-> accum_ff == '0)
      else $error("size accumulator not clear outside the size digits");

endmodule

FILE: hw/rtl/hcbd_out.sv
// Result register with one skid entry, decoupling the decoder from rsp_tready.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_out
   import hcbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   input  hcbd_result_type res,
   output logic            space_ok,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hcbd_result_type rsp
);

   logic            out_valid_ff;
   hcbd_result_type out_data_ff;
   logic            skid_valid_ff;
   hcbd_result_type skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : res;
      end else if (res_valid) begin
         skid_data_ff <= res;
      end
   end

   assign space_ok  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(skid_valid_ff && res_valid))
      else $error("result arrived while skid entry full");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

endmodule

FILE: tb/tb_http_chunked_body_decoder_unit.sv
// Self-checking testbench for http_chunked_body_decoder_unit: streams chunked bodies
// in, predicts payload bytes and completions, and checks every result in order.
// Depends on hcbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_unit;
   import hcbd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned BODY_BYTES    = 2000;   // random stimulus stops once this many are sent
   localparam int unsigned QUIET_FROM    = 700;    // no idling on either side in this span
   localparam int unsigned QUIET_TO      = 1100;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam logic [7:0]  CHAR_SEMI     = 8'h3B;

   localparam logic [SIZE_BITS-1:0]   SIZE_MAX   = '1;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   // Decoder phases as seen by the predictor.
   typedef enum logic [3:0] {
      ST_LEAD, ST_DIGITS, ST_REST, ST_DATA, ST_SKIP_A, ST_SKIP_B, ST_TRAILER
   } body_state_type;

   // Tracks the decoder state per accepted request and holds the results still owed.
   class chunk_decode_tracker;
      body_state_type         state;
      logic [SIZE_BITS-1:0]   size_acc;
      logic [SIZE_BITS-1:0]   bytes_left;
      logic [LENGTH_BITS-1:0] length_count;
      bit                     cr_pending;
      bit                     line_empty;
      bit                     size_sat;
      hcbd_result_type        expected_outputs[$];
      int unsigned            mismatches;

      function new();
         rearm();
         mismatches = 0;
      endfunction

      function void rearm();
         state        = ST_LEAD;
         size_acc     = '0;
         bytes_left   = '0;
         length_count = '0;
         cr_pending   = 1'b0;
         line_empty   = 1'b1;
         size_sat     = 1'b0;
      endfunction

      function int digit_value(logic [7:0] b);
         if (b >= "0" && b <= "9") return int'(b) - int'("0");
         if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
         if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
         return -1;
      endfunction

      function bit blank_char(logic [7:0] b);
         return b == CHAR_SP || b == CHAR_HT || b == CHAR_CR || b == CHAR_LF ||
                b == CHAR_VT || b == CHAR_FF;
      endfunction

      // Shift one hex digit into the size, clamping at all ones.
      function void shift_digit(logic [3:0] d);
         logic [SIZE_BITS+3:0] wide;
         if (size_acc > (SIZE_MAX >> 4)) begin
            size_acc = SIZE_MAX;
            size_sat = 1'b1;
         end else begin
            wide = ({4'b0, size_acc} << 4) + d;
            if (wide > {4'b0, SIZE_MAX}) begin
               size_acc = SIZE_MAX;
               size_sat = 1'b1;
            end else begin
               size_acc = wide[SIZE_BITS-1:0];
            end
         end
      endfunction

      function void note_body_byte(logic [7:0] b);
         bit              line_end;
         int              hv;
         hcbd_result_type r;
         line_end = cr_pending && b == CHAR_LF;
         case (state)
            ST_LEAD, ST_DIGITS, ST_REST: begin
               if (line_end) begin
                  cr_pending = 1'b0;
                  if (size_acc != 0) begin
                     bytes_left = size_acc;
                     state      = ST_DATA;
                  end else begin
                     line_empty = 1'b1;
                     state      = ST_TRAILER;
                  end
                  size_acc = '0;
               end else begin
                  cr_pending = (b == CHAR_CR);
                  hv = digit_value(b);
                  if (state == ST_LEAD) begin
                     if (hv >= 0) begin
                        shift_digit(hv[3:0]);
                        state = ST_DIGITS;
                     end else if (!blank_char(b)) begin
                        state = ST_REST;
                     end
                  end else if (state == ST_DIGITS) begin
                     if (hv >= 0) shift_digit(hv[3:0]);
                     else state = ST_REST;
                  end
               end
            end
            ST_DATA: begin
               if (length_count != LENGTH_MAX) length_count++;
               bytes_left--;
               if (bytes_left == 0) state = ST_SKIP_A;
               r.kind           = KIND_PAYLOAD;
               r.data_byte      = b;
               r.body_length    = BODY_LEN_W'(length_count);
               r.size_saturated = size_sat;
               expected_outputs.push_back(r);
            end
            ST_SKIP_A: state = ST_SKIP_B;
            ST_SKIP_B: begin
               state      = ST_LEAD;
               size_acc   = '0;
               cr_pending = 1'b0;
            end
            ST_TRAILER: begin
               if (line_end) begin
                  if (line_empty) begin
                     r.kind           = KIND_DONE;
                     r.data_byte      = 8'h00;
                     r.body_length    = BODY_LEN_W'(length_count);
                     r.size_saturated = size_sat;
                     expected_outputs.push_back(r);
                     rearm();
                  end else begin
                     cr_pending = 1'b0;
                     line_empty = 1'b1;
                  end
               end else begin
                  if (cr_pending) line_empty = 1'b0;
                  if (b == CHAR_CR) begin
                     cr_pending = 1'b1;
                  end else begin
                     cr_pending = 1'b0;
                     line_empty = 1'b0;
                  end
               end
            end
            default: state = ST_LEAD;
         endcase
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_output(logic [RSP_DATA_W-1:0] tdata, logic tuser);
         hcbd_result_type want;
         if (expected_outputs.size() == 0) begin
            $error("unexpected result: tuser=%0d tdata=0x%0h", tuser, tdata);
            mismatches++;
            return;
         end
         want = expected_outputs.pop_front();
         compare_field("kind", want.kind, tuser);
         compare_field("data_byte", want.data_byte, tdata[7:0]);
         compare_field("body_length", want.body_length, tdata[39:8]);
         compare_field("size_saturated", want.size_saturated, tdata[40]);
         compare_field("tdata padding", 0, tdata[RSP_DATA_W-1:41]);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   logic                  steady      = 1'b0;   // high: neither side idles
   int unsigned           cycle_count = 0;
   int unsigned           sent_count  = 0;
   logic [7:0]            body_bytes[$];        // bytes built but not yet sent

   chunk_decode_tracker   tracker = new();

   http_chunked_body_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hold reset at the start of the run, then release it for good.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Stall the result side about a third of the time, except in the steady span.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 34);
   end

   // Predict on every accepted request; check every accepted result against the oldest
   // expectation. A request is noted before a result in the same edge, which is safe
   // because a result always reaches rsp_ through the output register after its request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_body_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_output(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void put_byte(logic [7:0] b);
      body_bytes.push_back(b);
   endfunction

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
   endfunction

   function automatic void put_crlf();
      put_byte(CHAR_CR);
      put_byte(CHAR_LF);
   endfunction

   function automatic logic [7:0] random_other(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      do r = 8'($urandom_range(0, 255)); while (r == a || r == b);
      return r;
   endfunction

   // Emit a size in hex with random letter case and optional leading zeros.
   function automatic void put_size(int unsigned value, int unsigned zeros);
      logic [7:0]  digits[$];
      int unsigned v;
      int unsigned nib;
      v = value;
      do begin
         nib = v % 16;
         if (nib < 10) digits.push_front(8'("0" + nib));
         else if ($urandom_range(0, 1) != 0) digits.push_front(8'("a" + nib - 10));
         else digits.push_front(8'("A" + nib - 10));
         v = v / 16;
      end while (v != 0);
      repeat (zeros) put_byte("0");
      foreach (digits[i]) put_byte(digits[i]);
   endfunction

   // Whitespace before the size; a lone CR is always followed by a space so it never
   // closes the line.
   function automatic void put_lead_blanks();
      int unsigned pick;
      repeat ($urandom_range(0, 2)) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0: put_byte(CHAR_SP);
            1: put_byte(CHAR_HT);
            2: put_byte(CHAR_VT);
            3: put_byte(CHAR_FF);
            4: put_byte(CHAR_LF);
            default: begin
               put_byte(CHAR_CR);
               put_byte(CHAR_SP);
            end
         endcase
      end
   endfunction

   // Line text with no CR LF in it; now and then a bare CR followed by another byte.
   function automatic void put_line_text(int unsigned min_len, int unsigned max_len);
      repeat ($urandom_range(min_len, max_len)) begin
         if ($urandom_range(0, 7) == 0) begin
            put_byte(CHAR_CR);
            put_byte(random_other(CHAR_CR, CHAR_LF));
         end else begin
            put_byte(random_other(CHAR_CR, CHAR_CR));
         end
      end
   endfunction

   // What may follow the size digits: an extension, a bare CR, or nothing.
   function automatic void put_size_tail();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         put_byte(CHAR_SEMI);
         put_line_text(0, 5);
      end else if (pick == 3) begin
         put_byte(CHAR_CR);
         put_byte(random_other(CHAR_CR, CHAR_LF));
      end
   endfunction

   // One body: a few chunks, the last-chunk line, optional trailers, the empty line.
   // Mostly well formed; chunk tails, data and trailer lines carry some junk.
   function automatic void queue_random_body();
      int unsigned chunk_len;
      int unsigned pick;
      repeat ($urandom_range(1, 4)) begin
         put_lead_blanks();
         pick = $urandom_range(0, 9);
         if (pick < 6) chunk_len = $urandom_range(1, 12);
         else if (pick < 8) chunk_len = $urandom_range(10, 15);
         else if (pick < 9) chunk_len = $urandom_range(16, 64);
         else chunk_len = $urandom_range(65, 255);
         put_size(chunk_len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
         put_size_tail();
         put_crlf();
         repeat (chunk_len) begin
            if ($urandom_range(0, 15) == 0)
               put_byte(($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF);
            else
               put_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 7) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
            put_byte(8'($urandom_range(0, 255)));
         end else begin
            put_crlf();
         end
      end
      put_lead_blanks();
      if ($urandom_range(0, 5) == 0) begin
         // size line without digits
         if ($urandom_range(0, 1) != 0) begin
            put_byte(CHAR_SEMI);
            put_line_text(0, 4);
         end
      end else begin
         put_size(0, $urandom_range(0, 2));
         put_size_tail();
      end
      put_crlf();
      repeat ($urandom_range(0, 2)) begin
         put_line_text(1, 6);
         put_crlf();
      end
      put_crlf();
   endfunction

   // Send every queued byte, idling at random between requests outside the steady span.
   task automatic send_queued();
      logic [7:0] b;
      while (body_bytes.size() != 0) begin
         b = body_bytes.pop_front();
         while (!steady && $urandom_range(0, 99) < 34) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= b;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent_count++;
         steady <= (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
      end
   endtask

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);

      // Empty size line and empty trailer: completion with zero length.
      put_crlf();
      put_crlf();
      // Every leading blank but CR, an extension holding a bare CR, extreme data bytes,
      // a junk chunk tail, and one trailer line.
      put_byte(CHAR_SP);
      put_byte(CHAR_HT);
      put_byte(CHAR_VT);
      put_byte(CHAR_FF);
      put_byte(CHAR_LF);
      put_str("2;x");
      put_byte(CHAR_CR);
      put_str("Q");
      put_crlf();
      put_byte(8'h00);
      put_byte(8'hFF);
      put_str("zz");
      put_str("0");
      put_crlf();
      put_str("t");
      put_crlf();
      put_crlf();
      send_queued();

      while (sent_count < BODY_BYTES) begin
         queue_random_body();
         send_queued();
      end

      // Oversized chunk: the size clamps and every payload byte carries the flag. The
      // decoder stays inside this chunk, so it goes last.
      put_str("fFfFfFfFf0");
      put_crlf();
      repeat (40) put_byte(8'($urandom_range(0, 255)));
      send_queued();
      req_tvalid <= 1'b0;

      // Let the last request be noted, drain outstanding results, then settle.
      @(posedge clock);
      while (tracker.expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.expected_outputs.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
